// File: rtl/lcg_keystream_rotation_cipher_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the keystream rotation cipher
// Clocked, reset-qualified wrappers for same-cycle and next-cycle checks.
// ----------------------------------------------------------------------------
`ifndef LCG_KEYSTREAM_ROTATION_CIPHER_TOP_ASSERT_SVH
`define LCG_KEYSTREAM_ROTATION_CIPHER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define LKRC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed (same cycle)");

// Next-cycle implication, disabled while reset is high.
`define LKRC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed (next cycle)");

`endif

// File: rtl/lkrc_pkg.sv
// ----------------------------------------------------------------------------
// lkrc_pkg
// Types, constants and arithmetic helpers of the keystream rotation cipher.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lkrc_pkg;

   localparam int CHAR_W      = 7;
   localparam int GEN_W       = 17;
   localparam int SEED_W      = 16;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   typedef logic [CHAR_W-1:0]      char_type;
   typedef logic [GEN_W-1:0]       gen_type;
   typedef logic [SEED_W-1:0]      seed_type;
   typedef logic [CSR_INDEX_W-1:0] csr_index_type;
   typedef logic [CSR_DATA_W-1:0]  csr_data_type;

   // register indexes on the configuration port
   localparam csr_index_type CSR_DECRYPT_MODE = 2'd0;
   localparam csr_index_type CSR_INITIAL_SEED = 2'd1;

   localparam logic [6:0] LCG_MULT   = 7'd75;
   localparam gen_type    LCG_MOD    = 17'd65537;
   localparam gen_type    GEN_MAX    = 17'd65536;
   localparam gen_type    GEN_RESET  = 17'd1;
   localparam seed_type   SEED_RESET = 16'd1;
   localparam char_type   PRINT_BASE = 7'd32;
   localparam logic [7:0] PRINT_SPAN = 8'd96;

   // value * 75 mod 65537 by the 16-bit fold
   function automatic gen_type lcg_advance(input gen_type v);
      logic [23:0] prod;
      gen_type     lo;
      gen_type     hi;
      prod = {7'b0, v} * {17'b0, LCG_MULT};
      lo   = {1'b0, prod[15:0]};
      hi   = {9'b0, prod[23:16]};
      if (lo >= hi) begin
         lcg_advance = lo - hi;
      end else begin
         lcg_advance = lo + LCG_MOD - hi;
      end
   endfunction

   // v mod 96: split as 32 * q + r, then reduce q mod 3 by base-4 digit sums
   function automatic logic [6:0] mod_span(input gen_type v);
      logic [11:0] q;
      logic [4:0]  s1;
      logic [2:0]  s2;
      logic [1:0]  q3;
      q  = v[16:5];
      s1 = 5'(q[1:0]) + 5'(q[3:2]) + 5'(q[5:4]) + 5'(q[7:6])
         + 5'(q[9:8]) + 5'(q[11:10]);
      s2 = 3'(s1[1:0]) + 3'(s1[3:2]) + 3'(s1[4]);
      if (s2 >= 3'd6) begin
         q3 = 2'(s2 - 3'd6);
      end else if (s2 >= 3'd3) begin
         q3 = 2'(s2 - 3'd3);
      end else begin
         q3 = s2[1:0];
      end
      mod_span = {q3, v[4:0]};
   endfunction

   // rotate a printable character by k places within the printable range
   function automatic char_type rotate(input char_type c, input logic [6:0] k,
                                       input logic backward);
      logic [7:0] pos;
      logic [7:0] sum;
      if (c < PRINT_BASE) begin
         rotate = c;
      end else begin
         pos = {1'b0, c - PRINT_BASE};
         if (backward) begin
            sum = pos + PRINT_SPAN - {1'b0, k};
         end else begin
            sum = pos + {1'b0, k};
         end
         if (sum >= PRINT_SPAN) begin
            sum = sum - PRINT_SPAN;
         end
         rotate = sum[6:0] + PRINT_BASE;
      end
   endfunction

endpackage

`default_nettype wire

// File: rtl/lcg_keystream_rotation_cipher_top.sv
// ----------------------------------------------------------------------------
// lcg_keystream_rotation_cipher_top
// Stream cipher that rotates printable 7-bit characters by a Lehmer keystream.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel: one character per transfer, with req_message_start set on the
//   first character of a message (reloads the generator from initial_seed).
//   rsp_ channel: one rotated character per accepted request, in order.
//   csr_ channel: index 0 writes decrypt_mode, index 1 writes initial_seed;
//   other indexes are dropped. csr_ready is always high. Write only while idle.
// Path: a request is held in stage one, then rotated into the output register,
//   from which its response transfers.
// Throughput: one character per cycle without output stalls, set by the
//   generator feedback loop, a constant multiply by 75 and the mod-65537 fold
//   done in the request transfer cycle; mod-96 and rotate run in stage two.
// Reset: generator value 1, encrypt mode, seed 1, pipeline empty.
// Stall: while rsp_ready is low the result register holds, stage one keeps one
//   more character, and req_ready then drops until the output drains.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "lcg_keystream_rotation_cipher_top_assert.svh"

module lcg_keystream_rotation_cipher_top (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // request channel
   input  wire logic                   req_valid,
   output      logic                   req_ready,
   input  wire lkrc_pkg::char_type     req_char_in,
   input  wire logic                   req_message_start,
   // response channel
   output      logic                   rsp_valid,
   input  wire logic                   rsp_ready,
   output      lkrc_pkg::char_type     rsp_char_out,
   // configuration write channel
   input  wire logic                   csr_valid,
   output      logic                   csr_ready,
   input  wire lkrc_pkg::csr_index_type csr_index,
   input  wire lkrc_pkg::csr_data_type csr_wdata
);

   import lkrc_pkg::*;

   // configuration registers
   logic     decrypt_mode_ff, decrypt_mode_in;
   seed_type initial_seed_ff, initial_seed_in;

   // generator state: after a transfer it holds the value used by that item
   gen_type  gen_ff, gen_in;
   gen_type  gen_base;

   // stage one: character waiting for rotation
   logic     s1_vld_ff, s1_vld_in;
   char_type s1_char_ff, s1_char_in;

   // output register
   logic     rsp_valid_ff, rsp_valid_in;
   char_type rsp_char_ff, rsp_char_in;

   logic     req_xfer;
   logic     out_free;
   logic     s1_adv;

   // ---------------------------------------------------------------------
   // handshake
   // ---------------------------------------------------------------------
   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s1_adv    = s1_vld_ff && out_free;
   // stage one can take a character when empty or when it moves on this edge
   assign req_ready = !s1_vld_ff || out_free;
   assign req_xfer  = req_valid && req_ready;

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_char_out = rsp_char_ff;

   // ---------------------------------------------------------------------
   // configuration writes
   // ---------------------------------------------------------------------
   always_comb begin
      decrypt_mode_in = decrypt_mode_ff;
      initial_seed_in = initial_seed_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_DECRYPT_MODE: decrypt_mode_in = csr_wdata[0];
            CSR_INITIAL_SEED: initial_seed_in = csr_wdata[SEED_W-1:0];
            default: begin
               // drop writes to unknown indexes
            end
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // generator step and stage one load
   // ---------------------------------------------------------------------
   always_comb begin
      // reload from the seed on the first character of a message
      gen_base   = req_message_start ? {1'b0, initial_seed_ff} : gen_ff;
      gen_in     = gen_ff;
      s1_char_in = s1_char_ff;
      s1_vld_in  = s1_vld_ff;
      if (req_xfer) begin
         gen_in     = lcg_advance(gen_base);
         s1_char_in = req_char_in;
         s1_vld_in  = 1'b1;
      end else if (s1_adv) begin
         s1_vld_in  = 1'b0;
      end
   end

   // ---------------------------------------------------------------------
   // stage two: rotate by generator mod 96 into the output register
   // ---------------------------------------------------------------------
   always_comb begin
      rsp_char_in  = rsp_char_ff;
      rsp_valid_in = rsp_valid_ff;
      if (s1_adv) begin
         // gen_ff still belongs to the character in stage one: a new
         // transfer can only land on the same edge that moves it on
         rsp_char_in  = rotate(s1_char_ff, mod_span(gen_ff), decrypt_mode_ff);
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // ---------------------------------------------------------------------
   // registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         decrypt_mode_ff <= 1'b0;
         initial_seed_ff <= SEED_RESET;
         gen_ff          <= GEN_RESET;
         s1_vld_ff       <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         decrypt_mode_ff <= decrypt_mode_in;
         initial_seed_ff <= initial_seed_in;
         gen_ff          <= gen_in;
         s1_vld_ff       <= s1_vld_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      s1_char_ff  <= s1_char_in;
      rsp_char_ff <= rsp_char_in;
   end

   // ---------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------
   // the fold keeps the generator inside 0..65536
   `LKRC_ASSERT_NOW(a_gen_range, clock, reset, 1'b1, gen_ff <= GEN_MAX)

   // the generator only advances on a request transfer
   `LKRC_ASSERT_NEXT(a_gen_hold, clock, reset, !req_xfer, $stable(gen_ff))

   // a transferred request always sits in stage one on the next cycle
   `LKRC_ASSERT_NEXT(a_s1_load, clock, reset, req_xfer, s1_vld_ff)

   // control characters leave the block unchanged
   `LKRC_ASSERT_NEXT(a_ctrl_pass, clock, reset, s1_adv && (s1_char_ff < PRINT_BASE),
                     rsp_valid && (rsp_char_out == $past(s1_char_ff)))

endmodule

`default_nettype wire

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the keystream rotation cipher. A short directed
// table covers the corner cases; message-shaped random traffic follows under
// three idle patterns and several register settings. Every response is
// scored in order against a behavioral model of the generator and rotation.
// ----------------------------------------------------------------------------
module tb_top;
   import lkrc_pkg::*;

   // cipher arithmetic for the predictor
   localparam int unsigned KEY_MULTIPLIER  = 75;
   localparam int unsigned KEY_MODULUS     = 65537;
   localparam int unsigned PRINTABLE_LOW   = 32;
   localparam int unsigned PRINTABLE_COUNT = 128 - 32;

   // 20098 * 75 = -1 mod 65537, so this seed drives the generator to 65536
   localparam seed_type SEED_TO_TOP = 16'd20098;

   // indexes past the register list; writes there must be dropped
   localparam csr_index_type CSR_SPARE_2 = 2'd2;
   localparam csr_index_type CSR_SPARE_3 = 2'd3;

   localparam int SEGMENT_ITEMS = 305;
   localparam int PLAN_LEN      = 29;
   localparam int REPORT_LIMIT  = 10;

   typedef enum logic {ROW_CHAR, ROW_WRITE} row_kind_type;

   typedef struct {
      row_kind_type  kind;
      csr_index_type index;
      csr_data_type  data;      // character code or register value
      logic          start;
      bit            has_want;  // expected character typed into the table
      char_type      want;
   } plan_row_type;

   logic          clock;
   logic          reset;
   logic          req_valid;
   logic          req_ready;
   char_type      req_char_in;
   logic          req_message_start;
   logic          rsp_valid;
   logic          rsp_ready;
   char_type      rsp_char_out;
   logic          csr_valid;
   logic          csr_ready;
   csr_index_type csr_index;
   csr_data_type  csr_wdata;

   // model state, updated only from observed transfers
   gen_type     key_value;
   logic        decrypt_on;
   seed_type    seed_reg;
   char_type    expected_chars[$];
   int          fail_count = 0;

   // typed expectation for the character currently offered
   bit          cur_has_want;
   char_type    cur_want;

   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;
   int          send_calm = 0;
   int          recv_calm = 0;

   plan_row_type directed_plan [PLAN_LEN];

   lcg_keystream_rotation_cipher_top dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_char_in       (req_char_in),
      .req_message_start (req_message_start),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_char_out      (rsp_char_out),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Model
   // ------------------------------------------------------------------------

   // One Lehmer step: multiply by 75, then fold the product modulo 65537.
   function automatic gen_type next_key(input gen_type v);
      int unsigned product;
      int unsigned low_half;
      int unsigned high_half;
      product   = v * KEY_MULTIPLIER;
      low_half  = product % 65536;
      high_half = product / 65536;
      if (low_half >= high_half) begin
         return gen_type'(low_half - high_half);
      end
      return gen_type'(low_half + KEY_MODULUS - high_half);
   endfunction

   // Rotate a printable code by key mod 96; control codes pass through.
   function automatic char_type rotate_code(input char_type c, input gen_type key,
                                            input logic backward);
      int unsigned shift;
      int unsigned pos;
      if (c < PRINTABLE_LOW) begin
         return c;
      end
      shift = key % PRINTABLE_COUNT;
      pos   = c - PRINTABLE_LOW;
      if (backward) begin
         pos = (pos + PRINTABLE_COUNT - shift) % PRINTABLE_COUNT;
      end else begin
         pos = (pos + shift) % PRINTABLE_COUNT;
      end
      return char_type'(pos + PRINTABLE_LOW);
   endfunction

   task automatic log_fault(input string what);
      fail_count++;
      if (fail_count <= REPORT_LIMIT) begin
         $display("%0t ns: %s", $time, what);
      end
   endtask

   // ------------------------------------------------------------------------
   // Scoreboard: sample every channel at the rising edge. Score responses
   // first so a transfer never gets matched against its own request.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : score
      char_type want;
      if (reset) begin
         key_value  = 17'd1;
         decrypt_on = 1'b0;
         seed_reg   = 16'd1;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_chars.size() == 0) begin
               log_fault($sformatf("char_out %0d arrived with nothing outstanding",
                                   rsp_char_out));
            end else begin
               want = expected_chars.pop_front();
               if (rsp_char_out !== want) begin
                  log_fault($sformatf("char_out mismatch: expected %0d, got %0d",
                                      want, rsp_char_out));
               end
            end
         end
         if (req_valid && req_ready) begin
            // reload on message start, then always step before rotating
            if (req_message_start) begin
               key_value = seed_reg;
            end
            key_value = next_key(key_value);
            want      = rotate_code(req_char_in, key_value, decrypt_on);
            expected_chars.push_back(cur_has_want ? cur_want : want);
         end
         if (csr_valid && csr_ready) begin
            // mask to register width; unknown indexes change nothing
            case (csr_index)
               CSR_DECRYPT_MODE: decrypt_on = csr_wdata[0];
               CSR_INITIAL_SEED: seed_reg   = csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // ------------------------------------------------------------------------
   // Receiver: stall at random, with occasional calm stretches
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      if (recv_calm > 0) begin
         recv_calm--;
         rsp_ready <= 1'b1;
      end else if ($urandom_range(49) == 0) begin
         recv_calm = $urandom_range(40, 8);
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // ------------------------------------------------------------------------
   // Driver tasks. Each one starts and ends just after a falling edge.
   // ------------------------------------------------------------------------

   // Offer one character; hold it until the transfer completes.
   task automatic send_char(input char_type c, input logic s, input bit has_want,
                            input char_type want);
      csr_valid <= 1'b0;
      if (send_calm > 0) begin
         send_calm--;
      end else if ($urandom_range(49) == 0) begin
         send_calm = $urandom_range(40, 8);
      end else begin
         while ($urandom_range(99) < send_idle_pct) begin
            req_valid <= 1'b0;
            @(negedge clock);
         end
      end
      cur_has_want = has_want;
      cur_want     = want;
      req_valid         <= 1'b1;
      req_char_in       <= c;
      req_message_start <= s;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      @(negedge clock);
   endtask

   // Raise a register write and wait for its transfer; the next character
   // drops csr_valid, so back-to-back writes keep it high.
   task automatic write_register(input csr_index_type idx, input csr_data_type value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) begin
         @(posedge clock);
      end
      @(negedge clock);
   endtask

   // Hold the sender until every response is back, then let the pipe empty.
   task automatic settle_pipeline();
      req_valid <= 1'b0;
      do begin
         @(negedge clock);
      end while (expected_chars.size() != 0);
      // leave a margin after the last response
      repeat (4) @(negedge clock);
   endtask

   // One configuration followed by message-shaped random traffic.
   task automatic run_segment(input logic mode, input seed_type seed);
      int           msg_left;
      char_type     ch;
      logic         s;
      csr_data_type mode_word;
      msg_left  = 0;
      // junk in the upper bits must be masked off
      mode_word = (csr_data_type'($urandom) & 16'hFFFE) | csr_data_type'(mode);
      settle_pipeline();
      if ($urandom_range(1)) begin
         write_register(CSR_DECRYPT_MODE, mode_word);
         write_register(CSR_INITIAL_SEED, seed);
      end else begin
         write_register(CSR_INITIAL_SEED, seed);
         write_register(CSR_DECRYPT_MODE, mode_word);
      end
      if ($urandom_range(1)) begin
         write_register($urandom_range(1) ? CSR_SPARE_2 : CSR_SPARE_3,
                        csr_data_type'($urandom));
      end
      for (int n = 0; n < SEGMENT_ITEMS; n++) begin
         // halfway through, hold off until every response has come back
         if (n == SEGMENT_ITEMS / 2) begin
            settle_pipeline();
         end
         if (msg_left == 0) begin
            s        = 1'b1;
            msg_left = $urandom_range(40, 1);
         end else begin
            s = 1'b0;
         end
         msg_left--;
         // now and then a stray or missing start flag
         if ($urandom_range(19) == 0) begin
            s = ~s;
         end
         case ($urandom_range(9))
            0, 1: ch = char_type'($urandom_range(31));
            2: ch = $urandom_range(1) ? char_type'(127) : char_type'(PRINTABLE_LOW);
            default: ch = char_type'($urandom_range(127, PRINTABLE_LOW));
         endcase
         send_char(ch, s, 1'b0, '0);
      end
   endtask

   function automatic plan_row_type char_row(input char_type c, input logic s,
                                             input bit has_want, input char_type want);
      plan_row_type r;
      r.kind     = ROW_CHAR;
      r.index    = CSR_DECRYPT_MODE;
      r.data     = csr_data_type'(c);
      r.start    = s;
      r.has_want = has_want;
      r.want     = want;
      return r;
   endfunction

   function automatic plan_row_type write_row(input csr_index_type idx,
                                              input csr_data_type value);
      plan_row_type r;
      r.kind     = ROW_WRITE;
      r.index    = idx;
      r.data     = value;
      r.start    = 1'b0;
      r.has_want = 1'b0;
      r.want     = '0;
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------
   initial begin : stimulus
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_char_in       = '0;
      req_message_start = 1'b0;
      rsp_ready         = 1'b0;
      csr_valid         = 1'b0;
      csr_index         = CSR_DECRYPT_MODE;
      csr_wdata         = '0;
      cur_has_want      = 1'b0;
      cur_want          = '0;
      send_idle_pct     = 34;
      recv_idle_pct     = 70;

      directed_plan = '{
         // reset values: encrypt, seed 1; first step without a start flag
         char_row(7'd32,  1'b0, 1'b1, 7'd107),
         char_row(7'd0,   1'b0, 1'b1, 7'd0),
         char_row(7'd127, 1'b1, 1'b1, 7'd106),
         char_row(7'd31,  1'b0, 1'b1, 7'd31),
         char_row(7'd65,  1'b0, 1'b0, '0),
         char_row(7'd126, 1'b0, 1'b0, '0),
         char_row(7'd1,   1'b1, 1'b1, 7'd1),
         // decrypt undoes the first-step rotation of 75, wrap included
         write_row(CSR_DECRYPT_MODE, 16'hFFFF),
         char_row(7'd107, 1'b1, 1'b1, 7'd32),
         char_row(7'd106, 1'b1, 1'b1, 7'd127),
         char_row(7'd127, 1'b0, 1'b0, '0),
         char_row(7'd32,  1'b0, 1'b0, '0),
         char_row(7'd85,  1'b0, 1'b0, '0),
         // zero seed locks the generator at 0: everything passes through
         write_row(CSR_INITIAL_SEED, 16'h0000),
         char_row(7'd64,  1'b1, 1'b1, 7'd64),
         char_row(7'd127, 1'b0, 1'b1, 7'd127),
         char_row(7'd32,  1'b0, 1'b1, 7'd32),
         // writes past the register list must not disturb anything
         write_row(CSR_SPARE_2, 16'hFFFF),
         write_row(CSR_SPARE_3, 16'h0000),
         char_row(7'd80,  1'b0, 1'b1, 7'd80),
         // top seed, and mode 0 hidden under set upper bits
         write_row(CSR_DECRYPT_MODE, 16'hFFFE),
         write_row(CSR_INITIAL_SEED, 16'hFFFF),
         char_row(7'd33,  1'b1, 1'b0, '0),
         char_row(7'd90,  1'b0, 1'b0, '0),
         char_row(7'd5,   1'b1, 1'b1, 7'd5),
         // push the generator to 65536, then step out of it
         write_row(CSR_INITIAL_SEED, SEED_TO_TOP),
         char_row(7'd32,  1'b1, 1'b0, '0),
         char_row(7'd127, 1'b0, 1'b0, '0),
         char_row(7'd31,  1'b0, 1'b1, 7'd31)
      };

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // walk the table; drain the pipe ahead of each group of writes
      for (int i = 0; i < PLAN_LEN; i++) begin
         if (directed_plan[i].kind == ROW_WRITE) begin
            if (i == 0 || directed_plan[i - 1].kind != ROW_WRITE) begin
               settle_pipeline();
            end
            write_register(directed_plan[i].index, directed_plan[i].data);
         end else begin
            send_char(char_type'(directed_plan[i].data), directed_plan[i].start,
                      directed_plan[i].has_want, directed_plan[i].want);
         end
      end

      // sender lightly idle, receiver mostly stalled
      run_segment(1'b0, 16'd1);
      run_segment(1'b1, 16'hFFFF);

      // swap the roles
      send_idle_pct = 70;
      recv_idle_pct = 34;
      run_segment(1'b0, seed_type'($urandom_range(65535, 1)));
      run_segment(1'b1, SEED_TO_TOP);

      // full rate on both sides
      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_segment(1'b0, seed_type'($urandom_range(65535, 1)));
      run_segment(1'b1, seed_type'($urandom_range(65535, 1)));

      // drop the request, wait out the tail, then let strays show up
      req_valid <= 1'b0;
      csr_valid <= 1'b0;
      while (expected_chars.size() != 0) begin
         @(negedge clock);
      end
      repeat (8) @(negedge clock);

      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin : watchdog
      #5_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule
